// ===== rtl/core/srtf_pkg.sv =====
// shared constants and types for the srtf job scheduler
package srtf_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int IDX_W      = $clog2(MAX_JOBS);
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int LABEL_W    = 8;
  localparam int TIME_W     = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int REC_W      = LABEL_W + 2 * TIME_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/srtf_job_scheduler_unit.sv =====
// shortest-remaining-time-first job scheduler with a sequential slot scan
// add item: the beat goes through ST_ADD, which writes the next slot unless the table is full, then ST_FINISH
// tick item: ST_SCAN reads each used slot, ST_UPDATE writes back the served slot and advances time, then ST_FINISH
// one item in flight; the one ram read port visits one slot per cycle during a tick scan
// next item is taken the cycle after its result reaches the output register
// rst clears counters, time and handshake state; the slot table is not cleared
module srtf_job_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [srtf_pkg::LABEL_W-1:0]  job_label,
  input  logic [srtf_pkg::TIME_W-1:0]   arrival_time,
  input  logic [srtf_pkg::TIME_W-1:0]   run_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          rejected,
  output logic                          busy_res,
  output logic [srtf_pkg::LABEL_W-1:0]  served_label,
  output logic [srtf_pkg::SLOT_OUT_W-1:0] served_slot,
  output logic [srtf_pkg::TIME_W-1:0]   tick_time,
  output logic                          finished,
  output logic [srtf_pkg::TIME_W-1:0]   exit_time,
  output logic                          all_done
);

  srtf_pkg::state_t state, state_next;

  // captured input beat
  logic [srtf_pkg::LABEL_W-1:0]  label_q;
  logic [srtf_pkg::TIME_W-1:0]   arrival_q;
  logic [srtf_pkg::TIME_W-1:0]   length_q;

  logic [srtf_pkg::CNT_W-1:0]    slots_used;
  logic [srtf_pkg::CNT_W-1:0]    jobs_pending;
  logic [srtf_pkg::TIME_W-1:0]   current_time;

  // scan state
  logic [srtf_pkg::CNT_W-1:0]    scan_idx;
  logic                          rd_pend;
  logic [srtf_pkg::IDX_W-1:0]    rd_slot;
  logic                          found;
  logic [srtf_pkg::IDX_W-1:0]    best_slot;
  logic [srtf_pkg::LABEL_W-1:0]  best_label;
  logic [srtf_pkg::TIME_W-1:0]   best_arrival;
  logic [srtf_pkg::TIME_W-1:0]   best_rem;

  // result waiting for the output register
  logic                          res_rejected;
  logic                          res_busy;
  logic [srtf_pkg::LABEL_W-1:0]  res_label;
  logic [srtf_pkg::SLOT_OUT_W-1:0] res_slot;
  logic [srtf_pkg::TIME_W-1:0]   res_tick;
  logic                          res_finished;
  logic [srtf_pkg::TIME_W-1:0]   res_exit;
  logic                          res_all_done;

  // ram port
  logic                          ram_we;
  logic [srtf_pkg::IDX_W-1:0]    ram_waddr;
  logic [srtf_pkg::REC_W-1:0]    ram_wdata;
  logic [srtf_pkg::IDX_W-1:0]    ram_raddr;
  logic [srtf_pkg::REC_W-1:0]    ram_rdata;

  logic                          in_fire;
  logic                          out_free;
  logic                          table_full;
  logic                          scan_done;
  logic                          issue;
  logic [srtf_pkg::LABEL_W-1:0]  rd_label;
  logic [srtf_pkg::TIME_W-1:0]   rd_arrival;
  logic [srtf_pkg::TIME_W-1:0]   rd_rem;
  logic                          rd_take;
  logic [srtf_pkg::TIME_W-1:0]   rem_dec;
  logic [srtf_pkg::TIME_W-1:0]   time_inc;
  logic                          serve_done;

  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign table_full = (slots_used == srtf_pkg::CNT_W'(srtf_pkg::MAX_JOBS));
  assign scan_done  = (scan_idx == slots_used);
  assign issue      = (state == srtf_pkg::ST_SCAN) && !scan_done;

  assign rd_label   = ram_rdata[srtf_pkg::REC_W-1 -: srtf_pkg::LABEL_W];
  assign rd_arrival = ram_rdata[2*srtf_pkg::TIME_W-1 -: srtf_pkg::TIME_W];
  assign rd_rem     = ram_rdata[srtf_pkg::TIME_W-1:0];

  // one compare unit: eligibility and strict less-than keep the earliest slot on ties
  assign rd_take = rd_pend && (current_time >= rd_arrival) && (rd_rem != '0) &&
                   (!found || (best_rem > rd_rem));

  assign rem_dec    = best_rem - srtf_pkg::TIME_W'(1);
  assign serve_done = found && (best_rem == srtf_pkg::TIME_W'(1));
  assign time_inc   = (current_time == srtf_pkg::TIME_MAX) ? current_time
                                                           : current_time + srtf_pkg::TIME_W'(1);

  srtf_ram #(
    .WIDTH (srtf_pkg::REC_W),
    .DEPTH (srtf_pkg::MAX_JOBS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srtf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == srtf_pkg::FUNC_TICK) ? srtf_pkg::ST_SCAN : srtf_pkg::ST_ADD;
        end
      end
      srtf_pkg::ST_ADD:    state_next = srtf_pkg::ST_FINISH;
      srtf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = srtf_pkg::ST_UPDATE;
        end
      end
      srtf_pkg::ST_UPDATE: state_next = srtf_pkg::ST_FINISH;
      srtf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = srtf_pkg::ST_IDLE;
        end
      end
      default:             state_next = srtf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = slots_used[srtf_pkg::IDX_W-1:0];
    ram_wdata = {label_q, arrival_q, length_q};
    ram_raddr = scan_idx[srtf_pkg::IDX_W-1:0];
    case (state)
      srtf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      srtf_pkg::ST_ADD: begin
        ram_we = !table_full;
      end
      srtf_pkg::ST_UPDATE: begin
        ram_we    = found;
        ram_waddr = best_slot;
        ram_wdata = {best_label, best_arrival, rem_dec};
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srtf_pkg::ST_IDLE;
      slots_used   <= '0;
      jobs_pending <= '0;
      current_time <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
      found        <= 1'b0;
    end else begin
      state <= state_next;

      if (in_fire) begin
        label_q   <= job_label;
        arrival_q <= arrival_time;
        length_q  <= run_length;
        scan_idx  <= '0;
        rd_pend   <= 1'b0;
        found     <= 1'b0;
      end

      if (state == srtf_pkg::ST_SCAN) begin
        rd_pend <= issue;
        if (issue) begin
          rd_slot  <= scan_idx[srtf_pkg::IDX_W-1:0];
          scan_idx <= scan_idx + srtf_pkg::CNT_W'(1);
        end
        if (rd_take) begin
          found        <= 1'b1;
          best_slot    <= rd_slot;
          best_label   <= rd_label;
          best_arrival <= rd_arrival;
          best_rem     <= rd_rem;
        end
      end

      if (state == srtf_pkg::ST_ADD) begin
        res_rejected <= table_full;
        res_busy     <= 1'b0;
        res_label    <= '0;
        res_slot     <= '0;
        res_tick     <= current_time;
        res_finished <= 1'b0;
        res_exit     <= '0;
        res_all_done <= (jobs_pending == '0) &&
                        (table_full || (length_q == '0));
        if (!table_full) begin
          slots_used <= slots_used + srtf_pkg::CNT_W'(1);
          if (length_q != '0) begin
            jobs_pending <= jobs_pending + srtf_pkg::CNT_W'(1);
          end
        end
      end

      if (state == srtf_pkg::ST_UPDATE) begin
        res_rejected <= 1'b0;
        res_busy     <= found;
        res_label    <= found ? best_label : '0;
        res_slot     <= found ? srtf_pkg::SLOT_OUT_W'(best_slot) : '0;
        res_tick     <= current_time;
        res_finished <= serve_done;
        res_exit     <= serve_done ? time_inc : '0;
        if (serve_done && (jobs_pending != '0)) begin
          jobs_pending <= jobs_pending - srtf_pkg::CNT_W'(1);
          res_all_done <= (jobs_pending == srtf_pkg::CNT_W'(1));
        end else begin
          res_all_done <= (jobs_pending == '0);
        end
        current_time <= time_inc;
      end

      // output register: a held beat stays until taken
      if ((state == srtf_pkg::ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == srtf_pkg::ST_FINISH) && out_free) begin
      rejected     <= res_rejected;
      busy_res     <= res_busy;
      served_label <= res_label;
      served_slot  <= res_slot;
      tick_time    <= res_tick;
      finished     <= res_finished;
      exit_time    <= res_exit;
      all_done     <= res_all_done;
    end
  end

  a_slots_bounded: assert property (@(posedge clk) disable iff (rst)
    slots_used <= srtf_pkg::CNT_W'(srtf_pkg::MAX_JOBS))
    else $error("slot count beyond table size");

  a_pending_bounded: assert property (@(posedge clk) disable iff (rst)
    jobs_pending <= slots_used)
    else $error("more pending jobs than used slots");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> current_time >= $past(current_time))
    else $error("time went backwards");

  a_finish_needs_serve: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> busy_res && !rejected)
    else $error("finished without a served job");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == srtf_pkg::ST_SCAN |-> scan_idx <= slots_used)
    else $error("scan index ran past used slots");

endmodule

// ===== rtl/core/srtf_ram.sv =====
// generic single write, single read ram with registered read data
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/srtf_job_scheduler_checker.sv =====
// checker for the srtf scheduler: predicts each result beat and compares it field by field
`timescale 1ns / 100ps
module srtf_job_scheduler_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              func,
  input  logic [srtf_pkg::LABEL_W-1:0]      job_label,
  input  logic [srtf_pkg::TIME_W-1:0]       arrival_time,
  input  logic [srtf_pkg::TIME_W-1:0]       run_length,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              rejected,
  input  logic                              busy_res,
  input  logic [srtf_pkg::LABEL_W-1:0]      served_label,
  input  logic [srtf_pkg::SLOT_OUT_W-1:0]   served_slot,
  input  logic [srtf_pkg::TIME_W-1:0]       tick_time,
  input  logic                              finished,
  input  logic [srtf_pkg::TIME_W-1:0]       exit_time,
  input  logic                              all_done,
  output int                                fail_count,
  output int                                results_owed
);

  typedef struct packed {
    logic                            rej;
    logic                            busy;
    logic [srtf_pkg::LABEL_W-1:0]    label;
    logic [srtf_pkg::SLOT_OUT_W-1:0] slot;
    logic [srtf_pkg::TIME_W-1:0]     tick_t;
    logic                            fin;
    logic [srtf_pkg::TIME_W-1:0]     exit_t;
    logic                            done;
  } sched_result_t;

  sched_result_t sched_results_q[$];
  sched_result_t want_r;

  // shadow of the job table and scheduler counters
  logic [srtf_pkg::LABEL_W-1:0] tbl_label     [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::TIME_W-1:0]  tbl_arrival   [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::TIME_W-1:0]  tbl_remaining [srtf_pkg::MAX_JOBS];
  int                           used_slots;
  int                           pending_jobs;
  logic [srtf_pkg::TIME_W-1:0]  now_time;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("%0t ns: %s got %0h want %0h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic sched_result_t schedule_item(input logic f,
                                                  input logic [srtf_pkg::LABEL_W-1:0] lbl,
                                                  input logic [srtf_pkg::TIME_W-1:0] arr,
                                                  input logic [srtf_pkg::TIME_W-1:0] len);
    sched_result_t r;
    int            best;
    bit            found;
    r        = '0;
    best     = 0;
    found    = 1'b0;
    r.tick_t = now_time;
    if (f == srtf_pkg::FUNC_ADD) begin
      if (used_slots >= srtf_pkg::MAX_JOBS) begin
        r.rej = 1'b1;
      end else begin
        tbl_label[used_slots[srtf_pkg::IDX_W-1:0]]     = lbl;
        tbl_arrival[used_slots[srtf_pkg::IDX_W-1:0]]   = arr;
        tbl_remaining[used_slots[srtf_pkg::IDX_W-1:0]] = len;
        used_slots++;
        // a zero-length job takes a slot but is never pending
        if (len != '0) pending_jobs++;
      end
    end else begin
      for (int i = 0; i < used_slots; i++) begin
        if (now_time >= tbl_arrival[i[srtf_pkg::IDX_W-1:0]] &&
            tbl_remaining[i[srtf_pkg::IDX_W-1:0]] != '0) begin
          // strict compare keeps the earliest slot on a tie
          if (!found || tbl_remaining[best[srtf_pkg::IDX_W-1:0]] >
                        tbl_remaining[i[srtf_pkg::IDX_W-1:0]]) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        r.busy  = 1'b1;
        r.label = tbl_label[best[srtf_pkg::IDX_W-1:0]];
        r.slot  = best[srtf_pkg::SLOT_OUT_W-1:0];
        tbl_remaining[best[srtf_pkg::IDX_W-1:0]] =
          tbl_remaining[best[srtf_pkg::IDX_W-1:0]] - 1'b1;
        if (tbl_remaining[best[srtf_pkg::IDX_W-1:0]] == '0) begin
          r.fin    = 1'b1;
          r.exit_t = (now_time == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX : now_time + 1'b1;
          if (pending_jobs > 0) pending_jobs--;
        end
      end
      if (now_time != srtf_pkg::TIME_MAX) now_time = now_time + 1'b1;
    end
    r.done = (pending_jobs == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fail_count   = 0;
      used_slots   = 0;
      pending_jobs = 0;
      now_time     = '0;
      sched_results_q.delete();
    end else begin
      // result beat first: it always belongs to an earlier input beat
      if (out_valid && !out_stall) begin
        if (sched_results_q.size() == 0) begin
          report_mismatch("result beat with nothing expected, rejected/busy",
                          32'({rejected, busy_res}), '0);
        end else begin
          want_r = sched_results_q.pop_front();
          if (rejected !== want_r.rej)
            report_mismatch("rejected", 32'(rejected), 32'(want_r.rej));
          if (busy_res !== want_r.busy)
            report_mismatch("busy_res", 32'(busy_res), 32'(want_r.busy));
          if (served_label !== want_r.label)
            report_mismatch("served_label", 32'(served_label), 32'(want_r.label));
          if (served_slot !== want_r.slot)
            report_mismatch("served_slot", 32'(served_slot), 32'(want_r.slot));
          if (tick_time !== want_r.tick_t)
            report_mismatch("tick_time", 32'(tick_time), 32'(want_r.tick_t));
          if (finished !== want_r.fin)
            report_mismatch("finished", 32'(finished), 32'(want_r.fin));
          if (exit_time !== want_r.exit_t)
            report_mismatch("exit_time", 32'(exit_time), 32'(want_r.exit_t));
          if (all_done !== want_r.done)
            report_mismatch("all_done", 32'(all_done), 32'(want_r.done));
        end
      end
      if (in_valid && !in_stall) begin
        sched_results_q.push_back(schedule_item(func, job_label, arrival_time, run_length));
      end
    end
    results_owed = sched_results_q.size();
  end

endmodule

// ===== tb/srtf_job_scheduler_unit_tb.sv =====
// testbench top for the srtf scheduler: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module srtf_job_scheduler_unit_tb;

  localparam int PRE_SLOTS   = 8;       // slots filled before the table-full phase
  localparam int HOLD_CYCLES = 300;
  localparam int END_GUARD   = 100000;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic                            func         = srtf_pkg::FUNC_ADD;
  logic [srtf_pkg::LABEL_W-1:0]    job_label    = '0;
  logic [srtf_pkg::TIME_W-1:0]     arrival_time = '0;
  logic [srtf_pkg::TIME_W-1:0]     run_length   = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic                            rejected;
  logic                            busy_res;
  logic [srtf_pkg::LABEL_W-1:0]    served_label;
  logic [srtf_pkg::SLOT_OUT_W-1:0] served_slot;
  logic [srtf_pkg::TIME_W-1:0]     tick_time;
  logic                            finished;
  logic [srtf_pkg::TIME_W-1:0]     exit_time;
  logic                            all_done;

  int   fail_count;
  int   results_owed;
  int   send_idle_pct  = 35;
  int   recv_stall_pct = 79;
  logic hold_req       = 1'b0;
  logic hold_go        = 1'b0;
  int   clock_est      = 0;     // scheduler time as seen from the ticks sent so far
  int   slots_sent     = 0;
  int   guard;

  srtf_job_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .job_label    (job_label),
    .arrival_time (arrival_time),
    .run_length   (run_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rejected     (rejected),
    .busy_res     (busy_res),
    .served_label (served_label),
    .served_slot  (served_slot),
    .tick_time    (tick_time),
    .finished     (finished),
    .exit_time    (exit_time),
    .all_done     (all_done)
  );

  srtf_job_scheduler_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .job_label    (job_label),
    .arrival_time (arrival_time),
    .run_length   (run_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rejected     (rejected),
    .busy_res     (busy_res),
    .served_label (served_label),
    .served_slot  (served_slot),
    .tick_time    (tick_time),
    .finished     (finished),
    .exit_time    (exit_time),
    .all_done     (all_done),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      out_stall = hold_go || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    wait (hold_req);
    hold_go = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_go = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(input logic f, input logic [srtf_pkg::LABEL_W-1:0] lbl,
                           input logic [srtf_pkg::TIME_W-1:0] arr,
                           input logic [srtf_pkg::TIME_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func         = f;
    job_label    = lbl;
    arrival_time = arr;
    run_length   = len;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (f == srtf_pkg::FUNC_ADD) slots_sent++;
    else if (clock_est < srtf_pkg::TIME_MAX) clock_est++;
  endtask

  task automatic send_tick();
    send_item(srtf_pkg::FUNC_TICK, srtf_pkg::LABEL_W'($urandom),
              srtf_pkg::TIME_W'($urandom), srtf_pkg::TIME_W'($urandom));
  endtask

  task automatic random_phase(input int n_items, input int add_pct, input int slot_cap);
    logic                         f;
    logic [srtf_pkg::LABEL_W-1:0] lbl;
    logic [srtf_pkg::TIME_W-1:0]  arr;
    logic [srtf_pkg::TIME_W-1:0]  len;
    int                           near;
    int                           pick;
    repeat (n_items) begin
      f   = srtf_pkg::FUNC_TICK;
      lbl = srtf_pkg::LABEL_W'($urandom);
      arr = srtf_pkg::TIME_W'($urandom);
      len = srtf_pkg::TIME_W'($urandom);
      if (slots_sent < slot_cap && $urandom_range(99) < add_pct) begin
        f    = srtf_pkg::FUNC_ADD;
        // mostly jobs arriving now or shortly, some anywhere in the time range
        near = clock_est + $urandom_range(30);
        if ($urandom_range(4) != 0)
          arr = (near > srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX : near[srtf_pkg::TIME_W-1:0];
        pick = $urandom_range(9);
        if (pick == 0) len = '0;
        else if (pick < 7) len = srtf_pkg::TIME_W'($urandom_range(60, 1));
        else if (pick < 9) len = srtf_pkg::TIME_W'($urandom_range(3, 1));
      end
      send_item(f, lbl, arr, len);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle tick, zero-length job, late arrival, preemption, tie on remaining time
    send_tick();
    send_item(srtf_pkg::FUNC_ADD, 8'hff, 16'h0000, 16'h0000);
    send_tick();
    send_item(srtf_pkg::FUNC_ADD, 8'h00, 16'd5, 16'd3);
    send_item(srtf_pkg::FUNC_ADD, 8'h5a, 16'd0, 16'd5);
    repeat (2) send_tick();
    send_item(srtf_pkg::FUNC_ADD, 8'ha5, 16'd0, 16'd1);
    repeat (8) send_tick();

    // long result hold-off while beats keep coming
    hold_req = 1'b1;
    random_phase(400, 2, PRE_SLOTS - 1);
    send_idle_pct  = 79;
    recv_stall_pct = 35;
    random_phase(400, 2, PRE_SLOTS - 1);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid       = 1'b0;
    wait (results_owed == 0);
    @(negedge clk);

    // longest job, arriving at the last time value, stays pending to the end
    send_item(srtf_pkg::FUNC_ADD, 8'hff, srtf_pkg::TIME_MAX, srtf_pkg::TIME_MAX);
    // cap above table size so the table fills and later adds are refused
    random_phase(450, 30, srtf_pkg::MAX_JOBS + 4);
    in_valid = 1'b0;

    guard = 0;
    while (results_owed != 0 && guard < END_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== srtf_job_scheduler_unit.f =====
rtl/core/srtf_pkg.sv
rtl/core/srtf_ram.sv
rtl/core/srtf_job_scheduler_unit.sv
tb/srtf_job_scheduler_checker.sv
tb/srtf_job_scheduler_unit_tb.sv
